// File: rtl/i2crs_pkg.sv
// shared types and constants for the i2c register read sequencer
// used by i2crs_step and i2c_register_read_sequencer; depends on nothing
package i2crs_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_EVENT = 2'd1,
        OP_FETCH = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // actions requested from the bus controller
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_RECEIVE = 3'd4,
        ACT_ACK     = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    // step codes of the read sequence
    localparam logic [3:0] STEP_IDLE      = 4'd0;
    localparam logic [3:0] STEP_WR_ADDR   = 4'd1;
    localparam logic [3:0] STEP_COMMAND   = 4'd2;
    localparam logic [3:0] STEP_RESTART   = 4'd3;
    localparam logic [3:0] STEP_RD_ADDR   = 4'd4;
    localparam logic [3:0] STEP_RX_EN     = 4'd5;
    localparam logic [3:0] STEP_RX_LOW    = 4'd6;
    localparam logic [3:0] STEP_RX_HIGH   = 4'd7;
    localparam logic [3:0] STEP_STOP      = 4'd8;
    localparam logic [3:0] STEP_FINISH    = 4'd9;
    localparam logic [3:0] STEP_ERROR     = 4'd10;
    localparam logic [3:0] STEP_ERR_STOP  = 4'd11;
    localparam logic [3:0] STEP_ERR_CLEAR = 4'd12;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

    // one input word, first field highest
    typedef struct packed {
        logic [7:0] received_byte;
        logic       stop_seen;
        logic       receive_full;
        logic       ack_received;
        logic [7:0] command_byte;
        opcode_t    opcode;
    } item_t;

    // one result word, first field highest
    typedef struct packed {
        logic        busy_res;
        logic [15:0] reading;
        logic [7:0]  transmit_byte;
        action_t     bus_action;
    } result_t;

endpackage

// File: rtl/i2crs_step.sv
// sequencer state and the combinational step rule
// depends on i2crs_pkg
module i2crs_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  i2crs_pkg::item_t  item,
    input  logic [6:0]        device_address,
    output i2crs_pkg::result_t result
);
    import i2crs_pkg::*;

    logic [3:0] step_reg, step_next;
    logic       active_reg, active_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] high_reg, high_next;
    logic [3:0] step_inc;

    assign step_inc = step_reg + 4'd1;

    // step rule
    always_comb begin
        step_next     = step_reg;
        active_next   = active_reg;
        command_next  = command_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        result        = '0;
        result.bus_action = ACT_NONE;
        unique case (item.opcode)
            OP_START: begin
                active_next       = 1'b1;
                command_next      = item.command_byte;
                step_next         = STEP_IDLE;
                result.bus_action = ACT_START;
            end
            OP_EVENT: begin
                if (active_reg) begin
                    step_next = step_inc;
                    unique case (step_inc)
                        STEP_WR_ADDR: begin
                            result.bus_action    = ACT_SEND;
                            result.transmit_byte = {device_address, 1'b0};
                        end
                        STEP_COMMAND: begin
                            if (item.ack_received) begin
                                result.bus_action    = ACT_SEND;
                                result.transmit_byte = command_reg;
                            end else begin
                                step_next = STEP_ERROR;
                            end
                        end
                        STEP_RESTART: begin
                            if (item.ack_received) result.bus_action = ACT_RESTART;
                            else step_next = STEP_ERROR;
                        end
                        STEP_RD_ADDR: begin
                            result.bus_action    = ACT_SEND;
                            result.transmit_byte = {device_address, 1'b1};
                        end
                        STEP_RX_EN: begin
                            if (item.ack_received) result.bus_action = ACT_RECEIVE;
                            else step_next = STEP_ERROR;
                        end
                        STEP_RX_LOW: begin
                            if (item.receive_full) begin
                                low_next          = item.received_byte;
                                result.bus_action = ACT_RECEIVE;
                            end else begin
                                step_next = STEP_ERROR;
                            end
                        end
                        STEP_RX_HIGH: begin
                            if (item.receive_full) begin
                                high_next         = item.received_byte;
                                result.bus_action = ACT_ACK;
                            end else begin
                                step_next = STEP_ERROR;
                            end
                        end
                        STEP_STOP, STEP_ERR_STOP: begin
                            result.bus_action = ACT_STOP;
                        end
                        STEP_FINISH, STEP_ERR_CLEAR: begin
                            if (!item.stop_seen || step_inc == STEP_ERR_CLEAR) begin
                                low_next  = '0;
                                high_next = '0;
                            end
                            step_next   = STEP_IDLE;
                            active_next = 1'b0;
                        end
                        default: begin
                            step_next   = STEP_IDLE;
                            active_next = 1'b0;
                        end
                    endcase
                end
            end
            OP_FETCH: begin
                result.reading = {high_reg, low_reg};
                low_next       = '0;
                high_next      = '0;
            end
            default: ;
        endcase
        result.busy_res = active_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            active_reg  <= 1'b0;
            command_reg <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
        end else if (advance) begin
            step_reg    <= step_next;
            active_reg  <= active_next;
            command_reg <= command_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

endmodule

// File: rtl/i2c_register_read_sequencer.sv
// top level of the i2c register read sequencer: stream ports, apb register
// depends on i2crs_pkg and i2crs_step
//
// Usage:
//   s_ channel carries one word per controller request or bus event:
//   s_tuser is the opcode (start read, bus event, fetch), s_tdata the rest.
//   m_ channel returns exactly one result word per accepted input word:
//   the bus action to perform, the byte to send, the fetched reading and
//   the busy flag.
//   The apb port holds the seven-bit device address (reset 104) at
//   address 0; write it only while no word is in flight.
//   Each word passes an input register, then the combinational step rule,
//   then the result register, which drives m_tvalid.
//   Throughput is one word per cycle while m_tready stays high; the step
//   rule is combinational and the state updates on each advance, so
//   consecutive words never wait on each other.
//   When m_tready is low with a result waiting, the result register holds,
//   the input register still takes one more word if it is empty, and
//   s_tready then drops until the result is taken.
//   Reset (aresetn low, synchronous) empties both registers, returns the
//   sequence to idle and clears the stored command and data bytes.
module i2c_register_read_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // command_byte[7:0], ack_received[8],
                                  // receive_full[9], stop_seen[10],
                                  // received_byte[18:11], zero[23:19]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // bus_action[2:0], transmit_byte[10:3],
                                  // reading[26:11], busy_res[27], zero[31:28]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2crs_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    step_result;
    logic       advance;
    logic [6:0] dev_addr_reg;
    item_t      s_item;

    // unpack the input word
    assign s_item.opcode        = opcode_t'(s_tuser);
    assign s_item.command_byte  = s_tdata[7:0];
    assign s_item.ack_received  = s_tdata[8];
    assign s_item.receive_full  = s_tdata[9];
    assign s_item.stop_seen     = s_tdata[10];
    assign s_item.received_byte = s_tdata[18:11];

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    i2crs_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item           (in_item_reg),
        .device_address (dev_addr_reg),
        .result         (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_result_reg};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            dev_addr_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {25'd0, dev_addr_reg};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// testbench for i2c_register_read_sequencer: directed and random read sequences
// with an in-order result predictor; depends on i2crs_pkg and the sequencer rtl
module tb_top;
    import i2crs_pkg::*;

    localparam int        IDLE_LIMIT         = 1000;
    localparam int        SETTLE_CYCLES      = 6;
    localparam int        RANDOM_WORDS       = 1550;
    localparam int        MAX_PRINTED        = 40;
    localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // command_byte[7:0], ack_received[8], receive_full[9],
                                 // stop_seen[10], received_byte[18:11], zero[23:19]
    logic [1:0]  s_tuser  = '0;  // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // bus_action[2:0], transmit_byte[10:3], reading[26:11],
                                 // busy_res[27], zero[31:28]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_register_read_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // predicted sequencer state
    logic [6:0] dev_address;
    logic [3:0] seq_step;
    logic       seq_active;
    logic [7:0] seq_command;
    logic [7:0] data_low;
    logic [7:0] data_high;

    result_t bus_results_due[$];
    int      fail_count  = 0;
    int      work_words  = 0;
    int      quiet_cycles = 0;
    int      ready_left  = 0;
    bit      ready_phase = 1'b1;
    bit      no_gaps     = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTED)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // expected result of one word; advances the predicted state
    function automatic result_t next_bus_result(input item_t w);
        result_t r;
        r = '0;
        r.bus_action = ACT_NONE;
        case (w.opcode)
            OP_START: begin
                seq_active  = 1'b1;
                seq_command = w.command_byte;
                seq_step    = STEP_IDLE;
                r.bus_action = ACT_START;
            end
            OP_EVENT: begin
                if (seq_active) begin
                    seq_step = seq_step + 4'd1;
                    case (seq_step)
                        STEP_WR_ADDR: begin
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = {dev_address, 1'b0};
                        end
                        STEP_COMMAND: begin
                            if (w.ack_received) begin
                                r.bus_action    = ACT_SEND;
                                r.transmit_byte = seq_command;
                            end else
                                seq_step = STEP_ERROR;
                        end
                        STEP_RESTART: begin
                            if (w.ack_received) r.bus_action = ACT_RESTART;
                            else seq_step = STEP_ERROR;
                        end
                        STEP_RD_ADDR: begin
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = {dev_address, 1'b1};
                        end
                        STEP_RX_EN: begin
                            if (w.ack_received) r.bus_action = ACT_RECEIVE;
                            else seq_step = STEP_ERROR;
                        end
                        STEP_RX_LOW: begin
                            if (w.receive_full) begin
                                data_low     = w.received_byte;
                                r.bus_action = ACT_RECEIVE;
                            end else
                                seq_step = STEP_ERROR;
                        end
                        STEP_RX_HIGH: begin
                            if (w.receive_full) begin
                                data_high    = w.received_byte;
                                r.bus_action = ACT_ACK;
                            end else
                                seq_step = STEP_ERROR;
                        end
                        STEP_STOP, STEP_ERR_STOP: r.bus_action = ACT_STOP;
                        STEP_FINISH, STEP_ERR_CLEAR: begin
                            // data survives a clean finish only when a stop was seen
                            if (!w.stop_seen || seq_step == STEP_ERR_CLEAR) begin
                                data_low  = '0;
                                data_high = '0;
                            end
                            seq_step   = STEP_IDLE;
                            seq_active = 1'b0;
                        end
                        default: begin
                            seq_step   = STEP_IDLE;
                            seq_active = 1'b0;
                        end
                    endcase
                end
            end
            OP_FETCH: begin
                r.reading = {data_high, data_low};
                data_low  = '0;
                data_high = '0;
            end
            default: ;
        endcase
        r.busy_res = seq_active;
        return r;
    endfunction

    function automatic item_t make_word(input opcode_t op, input logic [7:0] cmd,
                                        input bit ack, input bit full, input bit stop,
                                        input logic [7:0] rx);
        item_t w;
        w.opcode        = op;
        w.command_byte  = cmd;
        w.ack_received  = ack;
        w.receive_full  = full;
        w.stop_seen     = stop;
        w.received_byte = rx;
        return w;
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic item_t random_word();
        return make_word(opcode_t'(2'($urandom_range(0, 3))), 8'($urandom), rand_bit(),
                         rand_bit(), rand_bit(), 8'($urandom));
    endfunction

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // drive one word, wait for its handshake, predict its result
    task automatic send_word(input item_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= w.opcode;
        s_tdata  <= {5'b0, w.received_byte, w.stop_seen, w.receive_full, w.ack_received,
                     w.command_byte};
        do @(posedge aclk); while (!s_tready);
        if (!(w.opcode == OP_NONE || (w.opcode == OP_EVENT && !seq_active)))
            work_words++;
        bus_results_due.push_back(next_bus_result(w));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_event(input bit ack, input bit full, input bit stop,
                              input logic [7:0] rx);
        send_word(make_word(OP_EVENT, 8'($urandom), ack, full, stop, rx));
    endtask

    // wait until every predicted word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (bus_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only called once drained: no word is in flight, though a read may still be active
    task automatic set_device_address(input logic [6:0] a);
        logic [31:0] rdata;
        drain();
        apb_access(1'b1, REG_DEVICE_ADDRESS, {25'b0, a}, rdata);
        dev_address = a;
        apb_access(1'b0, REG_DEVICE_ADDRESS, '0, rdata);
        if (rdata !== {25'b0, a}) report_mismatch("device_address readback", rdata, {25'b0, a});
    endtask

    // one start followed by events, with an occasional fetch, until the sequence ends or the guard runs out
    task automatic run_read_sequence(input int fault_pct);
        int guard;
        send_word(make_word(OP_START, 8'($urandom), rand_bit(), rand_bit(), rand_bit(),
                            8'($urandom)));
        guard = 0;
        while (seq_active && guard < 14) begin
            if ($urandom_range(0, 99) < 3)
                send_word(make_word(OP_FETCH, 8'($urandom), rand_bit(), rand_bit(),
                                    rand_bit(), 8'($urandom)));
            else
                send_event($urandom_range(0, 99) >= fault_pct,
                           $urandom_range(0, 99) >= fault_pct, rand_bit(), 8'($urandom));
            guard++;
        end
    endtask

    // clean read at the reset address, data kept because a stop was seen
    task automatic test_normal_read();
        no_gaps = 1'b1;
        send_word(make_word(OP_START, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00));
        send_event(1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b0, 1'b0, 8'h00);
        send_event(1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b1, 1'b0, 8'hFF);
        send_event(1'b1, 1'b1, 1'b0, 8'h00);
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
        send_word(make_word(OP_FETCH, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_word(make_word(OP_FETCH, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00));
        no_gaps = 1'b0;
    endtask

    // missing ack on the command: error, stop, clear
    task automatic test_error_path();
        send_word(make_word(OP_START, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
        send_event(1'b0, 1'b1, 1'b1, 8'hFF);
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
    endtask

    // idle events and the unused opcode are ignored
    task automatic test_ignored_words();
        send_event(1'b1, 1'b1, 1'b1, 8'hFF);
        send_word(make_word(OP_NONE, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    endtask

    // start over a running read, fetch while a read is active
    task automatic test_restart_and_fetch();
        send_word(make_word(OP_START, 8'h3C, 1'b0, 1'b0, 1'b0, 8'h00));
        send_event(1'b1, 1'b1, 1'b0, 8'h00);
        send_word(make_word(OP_START, 8'hC3, 1'b0, 1'b0, 1'b0, 8'h00));
        send_word(make_word(OP_FETCH, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
        send_word(make_word(OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
    endtask

    // address extremes and a random address, each with a clean read behind it, then the reset address again
    task automatic test_device_address();
        set_device_address(7'd0);
        run_read_sequence(0);
        set_device_address(7'd127);
        run_read_sequence(0);
        set_device_address(7'($urandom));
        run_read_sequence(0);
        set_device_address(DEV_ADDR_RESET);
    endtask

    // well-formed reads with random faults, broken up by noise words, with a new device address every 300 working words
    task automatic test_random_traffic();
        int start_count;
        int next_cfg;
        int roll;
        start_count = work_words;
        next_cfg    = 300;
        while (work_words - start_count < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 19) == 0);
            if (roll < 75) begin
                run_read_sequence($urandom_range(0, 1) ? 2 : 10);
                if ($urandom_range(0, 99) < 60)
                    send_word(make_word(OP_FETCH, 8'($urandom), rand_bit(), rand_bit(),
                                        rand_bit(), 8'($urandom)));
            end else begin
                repeat ($urandom_range(1, 6)) send_word(random_word());
            end
            if (work_words - start_count >= next_cfg) begin
                next_cfg += 300;
                roll = $urandom_range(0, 3);
                no_gaps = 1'b0;
                set_device_address(roll == 0 ? 7'd0 : roll == 1 ? 7'd127 : 7'($urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    // result receiver: random stalls, short mostly, with long ready runs
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_phase = ($urandom_range(0, 99) < 65);
            if (ready_phase) ready_left = $urandom_range(1, 30);
            else if ($urandom_range(0, 9) == 0) ready_left = $urandom_range(10, 40);
            else ready_left = $urandom_range(1, 3);
        end
        ready_left--;
        m_tready <= ready_phase || no_gaps;
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[27:0]);
            if (bus_results_due.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                want = bus_results_due.pop_front();
                if (got.bus_action !== want.bus_action)
                    report_mismatch("bus_action", 32'(got.bus_action), 32'(want.bus_action));
                if (got.transmit_byte !== want.transmit_byte)
                    report_mismatch("transmit_byte", 32'(got.transmit_byte),
                                    32'(want.transmit_byte));
                if (got.reading !== want.reading)
                    report_mismatch("reading", 32'(got.reading), 32'(want.reading));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        dev_address = DEV_ADDR_RESET;
        seq_step    = STEP_IDLE;
        seq_active  = 1'b0;
        seq_command = '0;
        data_low    = '0;
        data_high   = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_normal_read();
        test_error_path();
        test_ignored_words();
        test_restart_and_fetch();
        test_device_address();
        test_random_traffic();

        drain();
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: i2c_register_read_sequencer.f
rtl/i2crs_pkg.sv
rtl/i2crs_step.sv
rtl/i2c_register_read_sequencer.sv
test/tb_top.sv
